// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
// No dependencies; take in by include where concurrent checks are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, off while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication that also runs through reset.
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ===== rtl/bsfp_pkg.sv =====
// Shared types and constants of the bouquet association table section parser.
// No dependencies; compiled before the interfaces and modules.
`default_nettype none

package bsfp_pkg;

    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 3;
    localparam int LEN_W   = 12;
    localparam int ID_W    = 16;
    localparam int VER_W   = 5;
    localparam int WORD_W  = 32;

    // Record kinds on the output channel
    typedef enum logic [KIND_W-1:0] {
        KIND_HEADER     = 3'd0,
        KIND_BQ_DESC    = 3'd1,
        KIND_ENTRY      = 3'd2,
        KIND_ENTRY_DESC = 3'd3,
        KIND_END        = 3'd4
    } t_kind;

    // Input beat held in the input register
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
        logic              start;
    } t_beat;

    // One result record
    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] tbl_id;
        logic [LEN_W-1:0]  sec_length;
        logic [ID_W-1:0]   bouquet_id;
        logic [VER_W-1:0]  ver_num;
        logic              current_next;
        logic [BYTE_W-1:0] sec_num;
        logic [BYTE_W-1:0] last_sec_num;
        logic [LEN_W-1:0]  descriptor_length;
        logic [ID_W-1:0]   stream_id;
        logic [ID_W-1:0]   network_id;
        logic [WORD_W-1:0] payload;
    } t_rec;

endpackage

`default_nettype wire

// ===== rtl/bsfp_if.sv =====
// Valid/ready channel interfaces: section bytes in, parsed records out.
// Depends on bsfp_pkg for field widths.
`default_nettype none

interface bsfp_in_if;
    logic                           valid;
    logic                           ready;
    logic [bsfp_pkg::BYTE_W-1:0]    section_byte;
    logic                           section_start;

    modport source (output valid, output section_byte, output section_start, input ready);
    modport sink   (input valid, input section_byte, input section_start, output ready);
    modport mon    (input valid, input section_byte, input section_start, input ready);
endinterface

interface bsfp_out_if;
    logic                           valid;
    logic                           ready;
    logic [bsfp_pkg::KIND_W-1:0]    record_kind;
    logic [bsfp_pkg::BYTE_W-1:0]    tbl_id;
    logic [bsfp_pkg::LEN_W-1:0]     sec_length;
    logic [bsfp_pkg::ID_W-1:0]      bouquet_id;
    logic [bsfp_pkg::VER_W-1:0]     ver_num;
    logic                           current_next;
    logic [bsfp_pkg::BYTE_W-1:0]    sec_num;
    logic [bsfp_pkg::BYTE_W-1:0]    last_sec_num;
    logic [bsfp_pkg::LEN_W-1:0]     descriptor_length;
    logic [bsfp_pkg::ID_W-1:0]      stream_id;
    logic [bsfp_pkg::ID_W-1:0]      network_id;
    logic [bsfp_pkg::WORD_W-1:0]    payload;

    modport source (
        output valid, output record_kind, output tbl_id, output sec_length,
        output bouquet_id, output ver_num, output current_next,
        output sec_num, output last_sec_num, output descriptor_length,
        output stream_id, output network_id, output payload, input ready
    );
    modport sink (
        input valid, input record_kind, input tbl_id, input sec_length,
        input bouquet_id, input ver_num, input current_next,
        input sec_num, input last_sec_num, input descriptor_length,
        input stream_id, input network_id, input payload, output ready
    );
    modport mon (
        input valid, input record_kind, input tbl_id, input sec_length,
        input bouquet_id, input ver_num, input current_next,
        input sec_num, input last_sec_num, input descriptor_length,
        input stream_id, input network_id, input payload, input ready
    );
endinterface

`default_nettype wire

// ===== rtl/bat_section_field_parser.sv =====
// Bouquet association table section parser. Section bytes enter one per beat, a start
// flag marking the table id byte; records leave on a valid/ready channel: a header record
// on byte 9, one record per bouquet descriptor byte, one per 6-byte transport stream entry,
// one per entry descriptor byte, and an end record carrying the (unchecked) CRC_32 on the
// last byte. Throughput is one byte per clock unless the output stalls. A byte's record
// passes the input register, then the result register fed by the single-pass walker.
// A stalled output holds the result register and backs up through the input register.
// Depends on bsfp_pkg, bsfp_if, bsfp_in_stage and bsfp_core.
`default_nettype none

module bat_section_field_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bsfp_in_if.sink     i_sec,
    bsfp_out_if.source  o_rec
);
    import bsfp_pkg::*;

    t_beat w_beat;
    logic  w_take;
    logic  w_rec_valid;
    t_rec  w_rec;

    bsfp_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sec   (i_sec),
        .i_take  (w_take),
        .o_beat  (w_beat)
    );

    bsfp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_beat      (w_beat),
        .o_take      (w_take),
        .o_rec_valid (w_rec_valid),
        .i_rec_ready (o_rec.ready),
        .o_rec       (w_rec)
    );

    // Drive the record channel
    assign o_rec.valid             = w_rec_valid;
    assign o_rec.record_kind       = w_rec.kind;
    assign o_rec.tbl_id            = w_rec.tbl_id;
    assign o_rec.sec_length        = w_rec.sec_length;
    assign o_rec.bouquet_id        = w_rec.bouquet_id;
    assign o_rec.ver_num           = w_rec.ver_num;
    assign o_rec.current_next      = w_rec.current_next;
    assign o_rec.sec_num           = w_rec.sec_num;
    assign o_rec.last_sec_num      = w_rec.last_sec_num;
    assign o_rec.descriptor_length = w_rec.descriptor_length;
    assign o_rec.stream_id         = w_rec.stream_id;
    assign o_rec.network_id        = w_rec.network_id;
    assign o_rec.payload           = w_rec.payload;

endmodule

`default_nettype wire

// ===== rtl/bsfp_in_stage.sv =====
// Input register of the section parser: captures one section byte per beat.
// Depends on bsfp_pkg and bsfp_in_if.
`default_nettype none

module bsfp_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    bsfp_in_if.sink         i_sec,
    input  logic            i_take,
    output bsfp_pkg::t_beat o_beat
);
    import bsfp_pkg::*;

    logic              r_valid;
    logic [BYTE_W-1:0] r_data;
    logic              r_start;

    // Take a new beat when empty or when the held beat moves on this cycle
    assign i_sec.ready = !r_valid || i_take;

    // Hold the beat-valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_sec.valid && i_sec.ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // Capture the beat payload
    always_ff @(posedge i_clk) begin
        if (i_sec.valid && i_sec.ready) begin
            r_data  <= i_sec.section_byte;
            r_start <= i_sec.section_start;
        end
    end

    assign o_beat = '{valid: r_valid, data: r_data, start: r_start};

endmodule

`default_nettype wire

// ===== rtl/bsfp_core.sv =====
// Section walker of the parser: phase machine, header/entry/crc capture and
// the result register. Depends on bsfp_pkg.
`default_nettype none

module bsfp_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bsfp_pkg::t_beat i_beat,
    output logic            o_take,
    output logic            o_rec_valid,
    input  logic            i_rec_ready,
    output bsfp_pkg::t_rec  o_rec
);
    import bsfp_pkg::*;

    // Byte index runs to section length + 2, so it needs one bit more than the 12-bit length
    localparam int POS_W = LEN_W + 1;
    localparam int CNT_W = 3;
    localparam int ENT_W = 48;

    localparam logic [3:0] POS_TABLE_ID   = 4'd0;
    localparam logic [3:0] POS_SEC_LEN_HI = 4'd1;
    localparam logic [3:0] POS_SEC_LEN_LO = 4'd2;
    localparam logic [3:0] POS_BQ_ID_HI   = 4'd3;
    localparam logic [3:0] POS_BQ_ID_LO   = 4'd4;
    localparam logic [3:0] POS_VERSION    = 4'd5;
    localparam logic [3:0] POS_SEC_NUM    = 4'd6;
    localparam logic [3:0] POS_LAST_NUM   = 4'd7;
    localparam logic [3:0] POS_BQ_LEN_HI  = 4'd8;
    localparam logic [3:0] POS_BQ_LEN_LO  = 4'd9;

    localparam logic [LEN_W-1:0] MIN_SEC_LEN    = 12'd11;
    localparam logic [CNT_W-1:0] LOOP_LEN_BYTES = 3'd2;
    localparam logic [CNT_W-1:0] ENTRY_BYTES    = 3'd6;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_BQ_DESC,
        PH_LOOPLEN,
        PH_ENTRY,
        PH_ENTRY_DESC,
        PH_DONE
    } t_phase;

    // Control state
    t_phase             r_phase,  n_phase;
    logic [POS_W-1:0]   r_pos,    n_pos;
    logic [LEN_W-1:0]   r_rem,    n_rem;
    logic [CNT_W-1:0]   r_cnt,    n_cnt;
    logic               r_rec_valid;

    // Header, entry and crc capture
    logic [BYTE_W-1:0]  r_table_id,   n_table_id;
    logic [LEN_W-1:0]   r_sec_len,    n_sec_len;
    logic [ID_W-1:0]    r_bouquet_id, n_bouquet_id;
    logic [VER_W-1:0]   r_version,    n_version;
    logic               r_cur_next,   n_cur_next;
    logic [BYTE_W-1:0]  r_sec_num,    n_sec_num;
    logic [BYTE_W-1:0]  r_last_num,   n_last_num;
    logic [LEN_W-1:0]   r_bq_len,     n_bq_len;
    logic [ENT_W-1:0]   r_entry,      n_entry;
    logic [WORD_W-1:0]  r_crc,        n_crc;
    t_rec               r_rec,        n_rec;

    logic               n_emit;
    logic               w_work;
    logic               w_active;
    logic [POS_W-1:0]   w_len;
    logic [BYTE_W-1:0]  w_byte;
    t_kind              w_kind;
    logic [LEN_W-1:0]   w_dlen;
    logic [ID_W-1:0]    w_sid;
    logic [ID_W-1:0]    w_nid;
    logic [WORD_W-1:0]  w_payload;

    // Move the held beat when the result register is free or being drained
    assign o_take = !r_rec_valid || i_rec_ready;
    assign w_work = o_take && i_beat.valid;
    assign w_byte = i_beat.data;
    assign w_len  = {1'b0, r_sec_len};

    // Walk the section one byte
    always_comb begin
        n_phase      = r_phase;
        n_pos        = r_pos;
        n_rem        = r_rem;
        n_cnt        = r_cnt;
        n_table_id   = r_table_id;
        n_sec_len    = r_sec_len;
        n_bouquet_id = r_bouquet_id;
        n_version    = r_version;
        n_cur_next   = r_cur_next;
        n_sec_num    = r_sec_num;
        n_last_num   = r_last_num;
        n_bq_len     = r_bq_len;
        n_entry      = r_entry;
        n_crc        = r_crc;
        n_emit       = 1'b0;
        w_active     = 1'b0;
        w_kind       = KIND_HEADER;
        w_dlen       = '0;
        w_sid        = '0;
        w_nid        = '0;
        w_payload    = '0;

        // Restart on a start beat, otherwise advance inside a live section
        if (i_beat.start) begin
            n_phase  = PH_HEADER;
            n_pos    = '0;
            n_rem    = '0;
            n_cnt    = '0;
            w_active = 1'b1;
        end else if (r_phase != PH_IDLE && r_phase != PH_DONE) begin
            n_pos    = r_pos + POS_W'(1);
            w_active = 1'b1;
        end

        if (w_active) begin
            if (n_phase == PH_HEADER) begin
                // Capture header bytes by position
                unique case (n_pos[3:0])
                    POS_TABLE_ID:   n_table_id          = w_byte;
                    POS_SEC_LEN_HI: n_sec_len[11:8]     = w_byte[3:0];
                    POS_SEC_LEN_LO: n_sec_len[7:0]      = w_byte;
                    POS_BQ_ID_HI:   n_bouquet_id[15:8]  = w_byte;
                    POS_BQ_ID_LO:   n_bouquet_id[7:0]   = w_byte;
                    POS_VERSION: begin
                        n_version  = w_byte[5:1];
                        n_cur_next = w_byte[0];
                    end
                    POS_SEC_NUM:    n_sec_num           = w_byte;
                    POS_LAST_NUM:   n_last_num          = w_byte;
                    POS_BQ_LEN_HI:  n_bq_len[11:8]      = w_byte[3:0];
                    POS_BQ_LEN_LO:  n_bq_len[7:0]       = w_byte;
                    default: ;
                endcase
                // Header complete: pick the body phase and emit the header
                if (n_pos == POS_W'(POS_BQ_LEN_LO)) begin
                    n_rem = n_bq_len;
                    n_cnt = '0;
                    if (r_sec_len < MIN_SEC_LEN) begin
                        n_phase = PH_DONE;
                    end else if (n_bq_len != '0) begin
                        n_phase = PH_BQ_DESC;
                    end else begin
                        n_phase = PH_LOOPLEN;
                    end
                    n_emit = 1'b1;
                    w_kind = KIND_HEADER;
                    w_dlen = n_bq_len;
                end
            end else if (n_pos >= w_len - POS_W'(1)) begin
                // Last four bytes: shift into the crc word only
                n_crc = {r_crc[WORD_W-BYTE_W-1:0], w_byte};
                if (n_pos == w_len + POS_W'(2)) begin
                    n_phase   = PH_DONE;
                    n_emit    = 1'b1;
                    w_kind    = KIND_END;
                    w_payload = n_crc;
                end
            end else begin
                unique case (r_phase)
                    PH_BQ_DESC: begin
                        n_rem = r_rem - LEN_W'(1);
                        if (n_rem == '0) begin
                            n_phase = PH_LOOPLEN;
                            n_cnt   = '0;
                        end
                        n_emit    = 1'b1;
                        w_kind    = KIND_BQ_DESC;
                        w_dlen    = r_bq_len;
                        w_payload = WORD_W'(w_byte);
                    end
                    PH_LOOPLEN: begin
                        // Drop the two loop-length bytes
                        n_cnt = r_cnt + CNT_W'(1);
                        if (n_cnt >= LOOP_LEN_BYTES) begin
                            n_phase = PH_ENTRY;
                            n_cnt   = '0;
                        end
                    end
                    PH_ENTRY: begin
                        n_entry = {r_entry[ENT_W-BYTE_W-1:0], w_byte};
                        n_cnt   = r_cnt + CNT_W'(1);
                        if (n_cnt == ENTRY_BYTES) begin
                            n_cnt   = '0;
                            n_rem   = n_entry[LEN_W-1:0];
                            n_phase = (n_entry[LEN_W-1:0] != '0) ? PH_ENTRY_DESC : PH_ENTRY;
                            n_emit  = 1'b1;
                            w_kind  = KIND_ENTRY;
                            w_dlen  = n_entry[LEN_W-1:0];
                            w_sid   = n_entry[47:32];
                            w_nid   = n_entry[31:16];
                        end
                    end
                    PH_ENTRY_DESC: begin
                        n_rem = r_rem - LEN_W'(1);
                        if (n_rem == '0) begin
                            n_phase = PH_ENTRY;
                            n_cnt   = '0;
                        end
                        n_emit    = 1'b1;
                        w_kind    = KIND_ENTRY_DESC;
                        w_dlen    = r_entry[LEN_W-1:0];
                        w_sid     = r_entry[47:32];
                        w_nid     = r_entry[31:16];
                        w_payload = WORD_W'(w_byte);
                    end
                    default: ;
                endcase
            end
        end

        // Assemble the record with the current header values
        n_rec.kind              = w_kind;
        n_rec.tbl_id            = n_table_id;
        n_rec.sec_length        = n_sec_len;
        n_rec.bouquet_id        = n_bouquet_id;
        n_rec.ver_num           = n_version;
        n_rec.current_next      = n_cur_next;
        n_rec.sec_num           = n_sec_num;
        n_rec.last_sec_num      = n_last_num;
        n_rec.descriptor_length = w_dlen;
        n_rec.stream_id         = w_sid;
        n_rec.network_id        = w_nid;
        n_rec.payload           = w_payload;
    end

    // Hold phase, counters, captured fields and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_pos       <= '0;
            r_rem       <= '0;
            r_cnt       <= '0;
            r_rec_valid <= 1'b0;
        end else if (w_work) begin
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_rem       <= n_rem;
            r_cnt       <= n_cnt;
            r_rec_valid <= n_emit;
        end else if (o_take) begin
            r_rec_valid <= 1'b0;
        end
        if (w_work) begin
            r_table_id   <= n_table_id;
            r_sec_len    <= n_sec_len;
            r_bouquet_id <= n_bouquet_id;
            r_version    <= n_version;
            r_cur_next   <= n_cur_next;
            r_sec_num    <= n_sec_num;
            r_last_num   <= n_last_num;
            r_bq_len     <= n_bq_len;
            r_entry      <= n_entry;
            r_crc        <= n_crc;
            r_rec        <= n_rec;
        end
    end

    assign o_rec_valid = r_rec_valid;
    assign o_rec       = r_rec;

endmodule

`default_nettype wire

// ===== rtl/bsfp_checker.sv =====
// Port-level checks of the section parser, bound to the top level.
// Depends on bsfp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module bsfp_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic                        i_ready,
    input  logic [bsfp_pkg::KIND_W-1:0] i_kind,
    input  logic [bsfp_pkg::ID_W-1:0]   i_stream_id,
    input  logic [bsfp_pkg::ID_W-1:0]   i_network_id,
    input  logic [bsfp_pkg::WORD_W-1:0] i_payload
);
    import bsfp_pkg::*;

    logic                                 w_stall;
    logic [KIND_W+WORD_W+2*ID_W-1:0]      w_held;
    logic                                 w_no_entry_kind;
    logic                                 w_byte_kind;

    assign w_stall         = i_valid && !i_ready;
    assign w_held          = {i_kind, i_payload, i_stream_id, i_network_id};
    assign w_no_entry_kind = i_valid && (i_kind == KIND_HEADER || i_kind == KIND_END);
    assign w_byte_kind     = i_valid && (i_kind == KIND_BQ_DESC || i_kind == KIND_ENTRY_DESC);

    // Hold a stalled record
    `ASSERT_NEXT(a_rec_hold, i_clk, i_rst_n, w_stall, i_valid && $stable(w_held))

    // Reset drops the record channel
    `ASSERT_NEXT_ALWAYS(a_rst_clear, i_clk, !i_rst_n, !i_valid)

    // Header and end records carry no entry
    `ASSERT_IMPLY(a_no_entry, i_clk, i_rst_n, w_no_entry_kind, {i_stream_id, i_network_id} == '0)

    // Descriptor-byte records carry a single byte
    `ASSERT_IMPLY(a_desc_byte, i_clk, i_rst_n, w_byte_kind, i_payload[31:8] == '0)

endmodule

bind bat_section_field_parser bsfp_checker u_bsfp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (o_rec.valid),
    .i_ready      (o_rec.ready),
    .i_kind       (o_rec.record_kind),
    .i_stream_id  (o_rec.stream_id),
    .i_network_id (o_rec.network_id),
    .i_payload    (o_rec.payload)
);

`default_nettype wire

// ===== bench/tb_bat_section_field_parser.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the bouquet association table section parser: random and
// directed sections in, parsed records checked against a byte-level section model.
// Depends on bsfp_pkg, bsfp_if and the bat_section_field_parser RTL.

module tb_bat_section_field_parser;

    import bsfp_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 450;
    localparam int HOLD_OFF_LEN = 150;
    localparam int DRAIN_CYCLES = 12;

    // Parse phases of the section walker
    typedef enum logic [2:0] {
        SEC_IDLE,
        SEC_HEADER,
        SEC_BQ_DESC,
        SEC_LOOP_LEN,
        SEC_ENTRY,
        SEC_ENTRY_DESC,
        SEC_DONE
    } t_sec_phase;

    // Section model plus the queue of records it still waits for
    class bat_record_tracker;
        t_sec_phase  phase;
        logic [15:0] pos;
        logic [7:0]  hdr [10];
        logic [11:0] desc_left;
        logic [47:0] entry_word;
        logic [2:0]  entry_cnt;
        logic [31:0] crc_word;
        t_rec        expected_q [$];
        int          errors;

        function new();
            clear();
            errors = 0;
        endfunction

        function void clear();
            phase = SEC_IDLE;
            pos = '0;
            foreach (hdr[i]) hdr[i] = '0;
            desc_left = '0;
            entry_word = '0;
            entry_cnt = '0;
            crc_word = '0;
        endfunction

        function logic [11:0] sec_len();
            return {hdr[1][3:0], hdr[2]};
        endfunction

        function logic [11:0] bq_len();
            return {hdr[8][3:0], hdr[9]};
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Queue one record carrying the current header values
        function void add_record(t_kind k, logic [11:0] dlen, logic [15:0] sid,
                                 logic [15:0] nid, logic [31:0] pay);
            t_rec r;
            r.kind              = k;
            r.tbl_id            = hdr[0];
            r.sec_length        = sec_len();
            r.bouquet_id        = {hdr[3], hdr[4]};
            r.ver_num           = hdr[5][5:1];
            r.current_next      = hdr[5][0];
            r.sec_num           = hdr[6];
            r.last_sec_num      = hdr[7];
            r.descriptor_length = dlen;
            r.stream_id         = sid;
            r.network_id        = nid;
            r.payload           = pay;
            expected_q.push_back(r);
        endfunction

        // Advance the model by one accepted input beat
        function void take_byte(logic [7:0] b, logic start);
            int unsigned slen;
            if (start) begin
                clear();
                phase = SEC_HEADER;
            end else if (phase == SEC_IDLE || phase == SEC_DONE) begin
                return;
            end else begin
                pos = pos + 16'd1;
            end

            // Collect the header, report it on byte 9
            if (phase == SEC_HEADER) begin
                if (pos < 16'd10)
                    hdr[pos] = b;
                if (pos < 16'd9)
                    return;
                slen = 32'(sec_len());
                desc_left = bq_len();
                entry_cnt = '0;
                if (slen < 11)
                    phase = SEC_DONE;
                else
                    phase = (desc_left != 0) ? SEC_BQ_DESC : SEC_LOOP_LEN;
                add_record(KIND_HEADER, bq_len(), '0, '0, '0);
                return;
            end

            // The last four bytes are the CRC, whatever the walker was doing
            slen = 32'(sec_len());
            if (pos >= slen - 1) begin
                crc_word = {crc_word[23:0], b};
                if (pos == slen + 2) begin
                    phase = SEC_DONE;
                    add_record(KIND_END, '0, '0, '0, crc_word);
                end
                return;
            end

            case (phase)
                SEC_BQ_DESC: begin
                    desc_left = desc_left - 12'd1;
                    if (desc_left == 0) begin
                        phase = SEC_LOOP_LEN;
                        entry_cnt = '0;
                    end
                    add_record(KIND_BQ_DESC, bq_len(), '0, '0, {24'd0, b});
                end
                SEC_LOOP_LEN: begin
                    entry_cnt = entry_cnt + 3'd1;
                    if (entry_cnt >= 3'd2) begin
                        phase = SEC_ENTRY;
                        entry_cnt = '0;
                    end
                end
                SEC_ENTRY: begin
                    entry_word = {entry_word[39:0], b};
                    entry_cnt = entry_cnt + 3'd1;
                    if (entry_cnt == 3'd6) begin
                        entry_cnt = '0;
                        desc_left = entry_word[11:0];
                        phase = (desc_left != 0) ? SEC_ENTRY_DESC : SEC_ENTRY;
                        add_record(KIND_ENTRY, entry_word[11:0], entry_word[47:32],
                                   entry_word[31:16], '0);
                    end
                end
                SEC_ENTRY_DESC: begin
                    desc_left = desc_left - 12'd1;
                    if (desc_left == 0) begin
                        phase = SEC_ENTRY;
                        entry_cnt = '0;
                    end
                    add_record(KIND_ENTRY_DESC, entry_word[11:0], entry_word[47:32],
                               entry_word[31:16], {24'd0, b});
                end
                default: ;
            endcase
        endfunction

        function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        // Match one output beat against the oldest expected record
        function void check_record(t_rec got);
            t_rec want;
            if (expected_q.size() == 0) begin
                $error("record_kind %0d arrived with no record expected", got.kind);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            cmp_field("record_kind", 32'(want.kind), 32'(got.kind));
            cmp_field("tbl_id", 32'(want.tbl_id), 32'(got.tbl_id));
            cmp_field("sec_length", 32'(want.sec_length), 32'(got.sec_length));
            cmp_field("bouquet_id", 32'(want.bouquet_id), 32'(got.bouquet_id));
            cmp_field("ver_num", 32'(want.ver_num), 32'(got.ver_num));
            cmp_field("current_next", 32'(want.current_next), 32'(got.current_next));
            cmp_field("sec_num", 32'(want.sec_num), 32'(got.sec_num));
            cmp_field("last_sec_num", 32'(want.last_sec_num), 32'(got.last_sec_num));
            cmp_field("descriptor_length", 32'(want.descriptor_length),
                      32'(got.descriptor_length));
            cmp_field("stream_id", 32'(want.stream_id), 32'(got.stream_id));
            cmp_field("network_id", 32'(want.network_id), 32'(got.network_id));
            cmp_field("payload", want.payload, got.payload);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    bsfp_in_if  sec_if ();
    bsfp_out_if rec_if ();

    bat_section_field_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sec   (sec_if),
        .o_rec   (rec_if)
    );

    bat_record_tracker tracker;
    t_rec              rec_seen;
    logic [7:0]        sec_q [$];
    int                src_idle_pct;
    int                snk_stall_pct;
    int                hold_cycles;
    int                items_sent;
    int unsigned       cycle_count;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Feed every accepted input beat to the model
    always @(posedge i_clk) begin
        if (i_rst_n && sec_if.valid && sec_if.ready)
            tracker.take_byte(sec_if.section_byte, sec_if.section_start);
    end

    // Check every accepted output beat
    always @(posedge i_clk) begin
        if (i_rst_n && rec_if.valid && rec_if.ready) begin
            rec_seen.kind              = t_kind'(rec_if.record_kind);
            rec_seen.tbl_id            = rec_if.tbl_id;
            rec_seen.sec_length        = rec_if.sec_length;
            rec_seen.bouquet_id        = rec_if.bouquet_id;
            rec_seen.ver_num           = rec_if.ver_num;
            rec_seen.current_next      = rec_if.current_next;
            rec_seen.sec_num           = rec_if.sec_num;
            rec_seen.last_sec_num      = rec_if.last_sec_num;
            rec_seen.descriptor_length = rec_if.descriptor_length;
            rec_seen.stream_id         = rec_if.stream_id;
            rec_seen.network_id        = rec_if.network_id;
            rec_seen.payload           = rec_if.payload;
            tracker.check_record(rec_seen);
        end
    end

    // Receiver: random stalls, plus a long hold-off when one is requested
    initial begin
        rec_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                rec_if.ready = 1'b0;
                hold_cycles--;
            end else begin
                rec_if.ready = ($urandom_range(0, 99) >= snk_stall_pct);
            end
        end
    end

    // Offer one beat and hold it until taken; enter and leave at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic s);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            sec_if.valid = 1'b0;
            sec_if.section_byte = 8'($urandom_range(0, 255));
            sec_if.section_start = 1'($urandom_range(0, 1));
            @(negedge i_clk);
        end
        sec_if.valid = 1'b1;
        sec_if.section_byte = b;
        sec_if.section_start = s;
        do @(posedge i_clk); while (!sec_if.ready);
        @(negedge i_clk);
    endtask

    // Send the first n bytes of the built section, start flag on byte 0
    task automatic send_section(input int n);
        for (int i = 0; i < n; i++)
            send_byte(sec_q[i], i == 0);
        items_sent += n;
    endtask

    function automatic int pick_len();
        return ($urandom_range(0, 99) < 5) ? $urandom_range(4, 30) : $urandom_range(0, 3);
    endfunction

    // Build a consistent section into sec_q with random content
    task automatic make_good_section(input int bq_n, input int n_ent);
        logic [7:0]  body [$];
        logic [7:0]  rnd;
        logic [11:0] len12;
        logic [11:0] bq12;
        logic [11:0] d12;
        body = {};
        for (int i = 0; i < bq_n; i++)
            body.push_back(8'($urandom_range(0, 255)));
        // loop length, never checked by the block
        body.push_back(8'($urandom_range(0, 255)));
        body.push_back(8'($urandom_range(0, 255)));
        for (int i = 0; i < n_ent; i++) begin
            d12 = 12'(pick_len());
            rnd = 8'($urandom_range(0, 255));
            repeat (4) body.push_back(8'($urandom_range(0, 255)));
            body.push_back({rnd[7:4], d12[11:8]});
            body.push_back(d12[7:0]);
            for (int k = 0; k < d12; k++)
                body.push_back(8'($urandom_range(0, 255)));
        end
        repeat (4) body.push_back(8'($urandom_range(0, 255)));

        len12 = 12'(body.size() + 7);
        bq12 = 12'(bq_n);
        sec_q = {};
        sec_q.push_back(8'($urandom_range(0, 255)));
        rnd = 8'($urandom_range(0, 255));
        sec_q.push_back({rnd[7:4], len12[11:8]});
        sec_q.push_back(len12[7:0]);
        repeat (5) sec_q.push_back(8'($urandom_range(0, 255)));
        rnd = 8'($urandom_range(0, 255));
        sec_q.push_back({rnd[7:4], bq12[11:8]});
        sec_q.push_back(bq12[7:0]);
        foreach (body[i]) sec_q.push_back(body[i]);
    endtask

    // Overwrite the section length field of the built section
    task automatic patch_len(input logic [11:0] len12);
        sec_q[1] = {sec_q[1][7:4], len12[11:8]};
        sec_q[2] = len12[7:0];
    endtask

    // One random section: mostly well formed, the rest short, mislabeled or cut off
    task automatic send_random_section();
        int          pick;
        int          total;
        logic [11:0] fake;
        if ($urandom_range(0, 99) < 20)
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
        pick = $urandom_range(0, 99);
        make_good_section(pick_len(), $urandom_range(0, 4));
        if (pick < 65) begin
            send_section(sec_q.size());
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
        end else if (pick < 77) begin
            // short section: header only, the rest is dropped
            patch_len(12'($urandom_range(0, 10)));
            send_section(10 + $urandom_range(0, 3));
        end else if (pick < 89) begin
            fake = ($urandom_range(0, 7) == 0) ? 12'hFFF
                                              : 12'($urandom_range(11, sec_q.size() + 4));
            patch_len(fake);
            total = int'(fake) + 3;
            if (fake != 12'hFFF) begin
                while (sec_q.size() < total)
                    sec_q.push_back(8'($urandom_range(0, 255)));
            end
            send_section(sec_q.size());
        end else begin
            // abandoned: the next start cuts this one off
            send_section($urandom_range(1, sec_q.size() - 1));
        end
    endtask

    initial begin
        int target;
        tracker = new();
        sec_if.valid = 1'b0;
        sec_if.section_byte = '0;
        sec_if.section_start = 1'b0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        hold_cycles = 0;
        items_sent = 0;
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Bytes before any start are dropped
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);

        // Short section, all header bytes but the length field set to ones: header record only
        sec_q = {8'hFF, 8'hF0, 8'h0A, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_section(10);
        send_byte(8'h5A, 1'b0);

        // Minimal section that yields every record kind
        sec_q = {8'h4A, 8'hF0, 8'h15, 8'h00, 8'h00, 8'hC1, 8'h00, 8'h00, 8'hF0, 8'h01,
                 8'hA5, 8'hF0, 8'h07, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hF0, 8'h01,
                 8'h3C, 8'hDE, 8'hAD, 8'hBE, 8'hEF};
        send_section(24);

        // Random phases: no idling, sender idle, receiver stalling, both light
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 64; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 64; end
                default: begin src_idle_pct = 6; snk_stall_pct = 6; end
            endcase
            target = items_sent + PHASE_ITEMS;
            // long receiver hold-off while the sender keeps offering beats
            if (ph == 0 || ph == 3)
                hold_cycles = HOLD_OFF_LEN;
            while (items_sent < target)
                send_random_section();
        end
        sec_if.valid = 1'b0;

        // Drain, then wait on for anything stray
        while (tracker.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            if (tracker.pending() != 0)
                $error("%0d expected records never arrived", tracker.pending());
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== bat_section_field_parser.f =====
+incdir+rtl
rtl/bsfp_pkg.sv
rtl/bsfp_if.sv
rtl/bsfp_in_stage.sv
rtl/bsfp_core.sv
rtl/bat_section_field_parser.sv
rtl/bsfp_checker.sv
bench/tb_bat_section_field_parser.sv
